### src/llt_pkg.sv
`timescale 1ns / 1ps

package llt_pkg;

   localparam int unsigned TIME_BITS  = 48;
   localparam int unsigned LEASE_BITS = 31;
   localparam int unsigned FIELD_BITS = 16;
   localparam int unsigned COUNT_BITS = 5;

   typedef enum logic [2:0] {
      OP_ACQUIRE     = 3'd0,
      OP_RENEW       = 3'd1,
      OP_RELEASE     = 3'd2,
      OP_RELEASE_ALL = 3'd3,
      OP_RECLAIM     = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_CONFLICT = 2'd1,
      ST_NOT_HELD = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]            op;
      logic [FIELD_BITS-1:0] res_key;
      logic [FIELD_BITS-1:0] owner_id;
      logic [LEASE_BITS-1:0] lease_ms;
      logic [TIME_BITS-1:0]  now_ms;
   } req_type;

   typedef struct packed {
      logic                  success;
      logic [1:0]            status;
      logic [COUNT_BITS-1:0] reclaimed_count;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic sweep_step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic sweep_last;
   } dp_sts_type;

endpackage

### src/llt_dp.sv
`timescale 1ns / 1ps

module llt_dp #(
   parameter int unsigned ENTRIES    = 16,
   parameter int unsigned KEY_BITS   = 16,
   parameter int unsigned OWNER_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  llt_pkg::req_type    req_data,
   input  llt_pkg::dp_cmd_type cmd,
   output llt_pkg::dp_sts_type sts,
   output llt_pkg::rsp_type    result
);

   localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned KW = (KEY_BITS < llt_pkg::FIELD_BITS) ?
                                KEY_BITS : llt_pkg::FIELD_BITS;
   localparam int unsigned OW = (OWNER_BITS < llt_pkg::FIELD_BITS) ?
                                OWNER_BITS : llt_pkg::FIELD_BITS;
   localparam int unsigned TW = llt_pkg::TIME_BITS;
   localparam int unsigned CW = llt_pkg::COUNT_BITS;

   // Entry storage; contents are only looked at while the valid bit is set.
   logic [KW-1:0] key_mem   [ENTRIES];
   logic [OW-1:0] owner_mem [ENTRIES];
   logic [TW-1:0] exp_mem   [ENTRIES];

   logic [ENTRIES-1:0] valid_ff, valid_in;

   logic [2:0]    op_ff;
   logic [KW-1:0] key_ff;
   logic [OW-1:0] owner_ff;
   logic [TW-1:0] now_ff;
   logic [TW-1:0] exp_new_ff;

   logic [IW-1:0] rd_idx_ff;
   logic [IW-1:0] chk_idx_ff;
   logic          chk_en_ff;
   logic [KW-1:0] key_rd_ff;
   logic [OW-1:0] owner_rd_ff;
   logic [TW-1:0] exp_rd_ff;

   logic          match_ff;
   logic          match_owner_ff;
   logic [IW-1:0] match_slot_ff;
   logic          free_ff;
   logic [IW-1:0] free_slot_ff;
   logic [CW-1:0] count_ff;

   logic [TW-1:0] age;
   logic          ent_valid, expired, key_eq, owner_eq;
   logic          is_acq, is_renew, is_rel, is_relall, is_reclaim;
   logic          purge_op, live;
   logic          purge_hit, relall_hit, match_hit, free_hit;
   logic          do_insert, do_refresh, do_release;
   logic          exp_we;
   logic [IW-1:0] exp_waddr;

   always_comb begin
      is_acq     = (op_ff == llt_pkg::OP_ACQUIRE);
      is_renew   = (op_ff == llt_pkg::OP_RENEW);
      is_rel     = (op_ff == llt_pkg::OP_RELEASE);
      is_relall  = (op_ff == llt_pkg::OP_RELEASE_ALL);
      is_reclaim = (op_ff == llt_pkg::OP_RECLAIM);
      purge_op   = is_acq || is_reclaim;

      // An entry is stale once its expiry is at or behind the current time
      // in wrapping order, i.e. the wrapped age has a clear top bit.
      age       = now_ff - exp_rd_ff;
      ent_valid = valid_ff[chk_idx_ff];
      expired   = !age[TW-1];
      key_eq    = (key_rd_ff == key_ff);
      owner_eq  = (owner_rd_ff == owner_ff);
      live      = ent_valid && !(purge_op && expired);

      purge_hit  = chk_en_ff && ent_valid && expired && purge_op;
      relall_hit = chk_en_ff && ent_valid && owner_eq && is_relall;
      match_hit  = chk_en_ff && live && key_eq && !match_ff &&
                   (is_acq || is_renew || is_rel);
      free_hit   = chk_en_ff && !live && !free_ff && is_acq;

      do_insert  = cmd.commit && is_acq && !match_ff && free_ff;
      do_refresh = cmd.commit && match_ff && match_owner_ff && (is_acq || is_renew);
      do_release = cmd.commit && match_ff && match_owner_ff && is_rel;
      exp_we     = do_insert || do_refresh;
      exp_waddr  = do_insert ? free_slot_ff : match_slot_ff;

      valid_in = valid_ff;
      if (purge_hit || relall_hit) begin
         valid_in[chk_idx_ff] = 1'b0;
      end
      if (do_insert) begin
         valid_in[free_slot_ff] = 1'b1;
      end
      if (do_release) begin
         valid_in[match_slot_ff] = 1'b0;
      end

      sts.sweep_last = (rd_idx_ff == IW'(ENTRIES - 1));
   end

   always_comb begin
      result = '0;
      case (op_ff)
         llt_pkg::OP_ACQUIRE: begin
            result.reclaimed_count = count_ff;
            if (match_ff) begin
               if (match_owner_ff) begin
                  result.success = 1'b1;
               end else begin
                  result.status = llt_pkg::ST_CONFLICT;
               end
            end else if (free_ff) begin
               result.success = 1'b1;
            end else begin
               result.status = llt_pkg::ST_FULL;
            end
         end
         llt_pkg::OP_RENEW: begin
            if (match_ff && match_owner_ff) begin
               result.success = 1'b1;
            end else begin
               result.status = llt_pkg::ST_NOT_HELD;
            end
         end
         llt_pkg::OP_RELEASE: begin
            if (match_ff && match_owner_ff) begin
               result.reclaimed_count = CW'(1);
            end else begin
               result.status = llt_pkg::ST_NOT_HELD;
            end
         end
         llt_pkg::OP_RELEASE_ALL, llt_pkg::OP_RECLAIM: begin
            result.reclaimed_count = count_ff;
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         rd_idx_ff      <= '0;
         chk_en_ff      <= 1'b0;
         match_ff       <= 1'b0;
         match_owner_ff <= 1'b0;
         free_ff        <= 1'b0;
         count_ff       <= '0;
      end else begin
         valid_ff  <= valid_in;
         chk_en_ff <= cmd.sweep_step;
         if (cmd.load_req) begin
            rd_idx_ff      <= '0;
            match_ff       <= 1'b0;
            match_owner_ff <= 1'b0;
            free_ff        <= 1'b0;
            count_ff       <= '0;
         end else begin
            if (cmd.sweep_step && !sts.sweep_last) begin
               rd_idx_ff <= rd_idx_ff + IW'(1);
            end
            if (match_hit) begin
               match_ff       <= 1'b1;
               match_owner_ff <= owner_eq;
            end
            if (free_hit) begin
               free_ff <= 1'b1;
            end
            if ((purge_hit || relall_hit) && (count_ff != {CW{1'b1}})) begin
               count_ff <= count_ff + CW'(1);
            end
         end
      end
   end

   // Request fields, slot numbers and read data carry no reset.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff      <= req_data.op;
         key_ff     <= req_data.res_key[KW-1:0];
         owner_ff   <= req_data.owner_id[OW-1:0];
         now_ff     <= req_data.now_ms;
         exp_new_ff <= req_data.now_ms + TW'(req_data.lease_ms);
      end
      if (cmd.sweep_step) begin
         chk_idx_ff <= rd_idx_ff;
      end
      if (match_hit) begin
         match_slot_ff <= chk_idx_ff;
      end
      if (free_hit) begin
         free_slot_ff <= chk_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep_step) begin
         key_rd_ff   <= key_mem[rd_idx_ff];
         owner_rd_ff <= owner_mem[rd_idx_ff];
         exp_rd_ff   <= exp_mem[rd_idx_ff];
      end
      if (do_insert) begin
         key_mem[free_slot_ff]   <= key_ff;
         owner_mem[free_slot_ff] <= owner_ff;
      end
      if (exp_we) begin
         exp_mem[exp_waddr] <= exp_new_ff;
      end
   end

endmodule

### src/llt_ctrl.sv
`timescale 1ns / 1ps

module llt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                out_free,
   output logic                rsp_load,
   input  llt_pkg::dp_sts_type sts,
   output llt_pkg::dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SWEEP,
      S_DRAIN,
      S_FINISH,
      S_HOLD
   } state_type;

   state_type state_ff;

   always_comb begin
      req_ready      = (state_ff == S_IDLE);
      cmd.load_req   = req_valid && req_ready;
      cmd.sweep_step = (state_ff == S_SWEEP);
      cmd.commit     = (state_ff == S_FINISH);
      rsp_load       = ((state_ff == S_FINISH) || (state_ff == S_HOLD)) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_SWEEP;
               end
            end
            S_SWEEP: begin
               if (sts.sweep_last) begin
                  state_ff <= S_DRAIN;
               end
            end
            // The last entry read is checked here.
            S_DRAIN: begin
               state_ff <= S_FINISH;
            end
            // Table updates happen once; the result may still wait in S_HOLD.
            S_FINISH: begin
               state_ff <= out_free ? S_IDLE : S_HOLD;
            end
            S_HOLD: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_accept_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_SWEEP))
      else $error("accepted transaction did not start a sweep");

   a_commit_single: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !cmd.commit)
      else $error("table update issued twice for one transaction");

   a_sweep_runs_out: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SWEEP) && !sts.sweep_last) |=> (state_ff == S_SWEEP))
      else $error("sweep left before the last entry");

   a_load_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !req_ready)
      else $error("result loaded while controller idle");

endmodule

### src/lease_lock_table.sv
`timescale 1ns / 1ps

// Leased lock table with ENTRIES slots. Requests are taken only in S_IDLE,
// after the previous request has left S_FINISH or S_HOLD. The controller walks
// the entry memory one slot per cycle through its single registered read port,
// purging, matching and counting as it goes, then checks the last slot in
// S_DRAIN and writes the table and produces the result in S_FINISH. The
// result sits in an output register, so a new request is taken while the
// previous result waits on rsp_ready. The table is empty right after reset;
// no clearing pass is needed. Keys and owners are compared on their low
// KEY_BITS and OWNER_BITS bits, capped at FIELD_BITS.
module lease_lock_table #(
   parameter int unsigned ENTRIES    = 16,
   parameter int unsigned KEY_BITS   = 16,
   parameter int unsigned OWNER_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  llt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output llt_pkg::rsp_type rsp_data
);

   llt_pkg::dp_cmd_type cmd;
   llt_pkg::dp_sts_type sts;
   llt_pkg::rsp_type    result;
   logic                rsp_load;
   logic                out_free;

   logic             rsp_valid_ff, rsp_valid_in;
   llt_pkg::rsp_type rsp_data_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= result;
      end
   end

   llt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .rsp_load  (rsp_load),
      .sts       (sts),
      .cmd       (cmd)
   );

   llt_dp #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .OWNER_BITS (OWNER_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .result   (result)
   );

endmodule
